// ===== hdl/sglt_pkg.sv =====
// Shared types and constants for the sequence gap loss tracker.
// No dependencies; used by sglt_table and sequence_gap_loss_tracker_top.
`timescale 1ns / 1ps
`default_nettype none

package sglt_pkg;

	localparam int SEQ_W  = 32;
	localparam int TIME_W = 64;
	localparam int CNT_W  = 32;

	// Input tdata: chunk_seq, arrival_time
	localparam int IN_W   = 96;
	// Output tdata: 193 payload bits padded to whole bytes
	localparam int RES_W  = 1 + TIME_W + 4 * CNT_W;
	localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

	// One slot of the missing-number table
	typedef struct packed {
		logic              valid;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// One result item
	typedef struct packed {
		logic [CNT_W-1:0]  loss_total;
		logic [CNT_W-1:0]  repaired_total;
		logic [CNT_W-1:0]  gap_dropped;
		logic [CNT_W-1:0]  gap_count;
		logic [TIME_W-1:0] repair_detect_time;
		logic              was_repaired;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/sglt_table.sv =====
// Slot memory of the tracker: one write port, one read port with registered data.
// Depends on sglt_pkg (entry_t).
`timescale 1ns / 1ps
`default_nettype none

module sglt_table #(
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire sglt_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output sglt_pkg::entry_t     rd_data
);

	sglt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sequence_gap_loss_tracker_top.sv =====
// Top level of the sequence gap loss tracker: sequencer, state registers, result register.
// Depends on sglt_pkg and sglt_table.
//
//  channel  | dir | tdata fields (lowest bit up)                               | width
//  ---------+-----+------------------------------------------------------------+------
//  s_axis   | in  | chunk_seq[31:0], arrival_time[95:32]                       |  96
//  m_axis   | out | was_repaired[0], repair_detect_time[64:1], gap_count[96:65],| 200
//           |     | gap_dropped[128:97], repaired_total[160:129],              |
//           |     | loss_total[192:161], zero pad[199:193]                     |
//
// Steps: the first chunk after reset is accepted, then finished. Later chunks walk
//   the slot memory through its single read port: lookup ends when the first hit slot
//   returns or every slot has been read; a gap adds a second walk that stops once every
//   skipped number has a slot or every slot has been read, then the finish step.
// Reset: arst_n clears control state, then a clearing pass marks every slot free;
//   s_axis_tready stays low until it is done.
// Stalls: the result register holds one finished transfer; the next chunk is taken
//   while it waits, and only the finish step waits for m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module sequence_gap_loss_tracker_top #(
	parameter int TABLE_SLOTS = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// chunk_seq[31:0], arrival_time[95:32]
	input  wire logic [sglt_pkg::IN_W-1:0]  s_axis_tdata,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// was_repaired, repair_detect_time, gap_count, gap_dropped, repaired_total,
	// loss_total, zero pad
	output logic [sglt_pkg::OUT_W-1:0]      m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready
);

	localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	// Scan counter also holds TABLE_SLOTS itself
	localparam int IW = $clog2(TABLE_SLOTS + 1);
	localparam logic [IW-1:0] SLOTS_C = IW'(TABLE_SLOTS);
	localparam logic [IW-1:0] LAST_C  = IW'(TABLE_SLOTS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_INS   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	// Control state
	logic [2:0]  state_q;
	logic [IW-1:0] cnt_q;
	logic        rd_pend_s1;
	logic        started_q;
	logic        hit_q;
	logic        m_valid_q;
	logic [sglt_pkg::CNT_W-1:0] rep_cnt_q;
	logic [sglt_pkg::CNT_W-1:0] loss_cnt_q;
	logic [sglt_pkg::SEQ_W-1:0] highest_q;

	// Payload
	logic [AW-1:0]               rd_idx_s1;
	logic [sglt_pkg::SEQ_W-1:0]  seq_q;
	logic [sglt_pkg::TIME_W-1:0] now_q;
	logic [sglt_pkg::TIME_W-1:0] hit_time_q;
	logic [sglt_pkg::CNT_W-1:0]  gap_q;
	logic [sglt_pkg::CNT_W-1:0]  left_q;
	logic [sglt_pkg::SEQ_W-1:0]  next_q;
	sglt_pkg::result_t           res_q;

	// Table port
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	sglt_pkg::entry_t wr_data;
	logic             rd_en;
	sglt_pkg::entry_t rd_data;

	logic in_fire;
	logic fin_fire;
	logic match;
	logic look_done;
	logic ins_done;
	logic gap_hit;
	logic [sglt_pkg::SEQ_W:0]   high_inc;
	logic [sglt_pkg::CNT_W-1:0] gap_val;
	sglt_pkg::result_t          res_next;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign fin_fire      = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

	// Gap test in 33 bits: highest at the top of the range makes no gap
	assign high_inc = {1'b0, highest_q} + {{sglt_pkg::SEQ_W{1'b0}}, 1'b1};
	assign gap_hit  = {1'b0, seq_q} > high_inc;
	assign gap_val  = seq_q - highest_q - 32'd1;

	// Returned slot compare, one slot per cycle
	assign match     = rd_pend_s1 && rd_data.valid && (rd_data.seq == seq_q);
	assign look_done = match || ((cnt_q == SLOTS_C) && !rd_pend_s1);
	assign ins_done  = (left_q == '0) || ((cnt_q == SLOTS_C) && !rd_pend_s1);

	assign rd_en = ((state_q == ST_LOOK) || (state_q == ST_INS)) && (cnt_q != SLOTS_C);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_idx_s1;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
			end
			ST_LOOK: begin
				// free the hit slot; seq and stamp no longer matter
				wr_en = match;
			end
			ST_INS: begin
				wr_en         = rd_pend_s1 && !rd_data.valid && (left_q != '0);
				wr_data.valid = 1'b1;
				wr_data.seq   = next_q;
				wr_data.stamp = now_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_next                    = '0;
		res_next.was_repaired       = hit_q;
		res_next.repair_detect_time = hit_time_q;
		res_next.gap_count          = gap_q;
		res_next.gap_dropped        = left_q;
		res_next.repaired_total     = rep_cnt_q + {{(sglt_pkg::CNT_W-1){1'b0}}, hit_q};
		res_next.loss_total         = loss_cnt_q + gap_q;
	end

	sglt_table #(
		.DEPTH (TABLE_SLOTS),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			rd_pend_s1 <= 1'b0;
			started_q  <= 1'b0;
			hit_q      <= 1'b0;
			m_valid_q  <= 1'b0;
			rep_cnt_q  <= '0;
			loss_cnt_q <= '0;
			highest_q  <= '0;
		end else begin
			if (fin_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_C) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						hit_q      <= 1'b0;
						cnt_q      <= '0;
						rd_pend_s1 <= 1'b0;
						state_q    <= started_q ? ST_LOOK : ST_FIN;
					end
				end
				ST_LOOK: begin
					if (match) begin
						hit_q <= 1'b1;
					end
					if (look_done) begin
						cnt_q      <= '0;
						rd_pend_s1 <= 1'b0;
						state_q    <= gap_hit ? ST_INS : ST_FIN;
					end else begin
						rd_pend_s1 <= rd_en;
						if (rd_en) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_INS: begin
					if (ins_done) begin
						cnt_q      <= '0;
						rd_pend_s1 <= 1'b0;
						state_q    <= ST_FIN;
					end else begin
						rd_pend_s1 <= rd_en;
						if (rd_en) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						rep_cnt_q  <= res_next.repaired_total;
						loss_cnt_q <= res_next.loss_total;
						started_q  <= 1'b1;
						if (!started_q || (seq_q > highest_q)) begin
							highest_q <= seq_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			seq_q      <= s_axis_tdata[31:0];
			now_q      <= s_axis_tdata[95:32];
			hit_time_q <= '0;
			gap_q      <= '0;
			left_q     <= '0;
		end
		if (rd_en) begin
			rd_idx_s1 <= cnt_q[AW-1:0];
		end
		if ((state_q == ST_LOOK) && match) begin
			hit_time_q <= rd_data.stamp;
		end
		if ((state_q == ST_LOOK) && look_done && gap_hit) begin
			gap_q  <= gap_val;
			left_q <= gap_val;
			next_q <= high_inc[sglt_pkg::SEQ_W-1:0];
		end
		if ((state_q == ST_INS) && wr_en) begin
			left_q <= left_q - 32'd1;
			next_q <= next_q + 32'd1;
		end
		if (fin_fire) begin
			res_q <= res_next;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(sglt_pkg::OUT_W - sglt_pkg::RES_W){1'b0}}, res_q};

`ifndef SYNTHESIS
	// Remaining skipped numbers never grow during the insert walk
	a_left_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |=> (left_q <= $past(left_q)))
		else $error("insert walk raised the pending gap count");

	// Slot memory is written only by clearing, lookup and insert
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == ST_CLEAR) || (state_q == ST_LOOK) || (state_q == ST_INS)))
		else $error("slot memory written outside a walk");

	// Dropped numbers are a part of the detected gap
	a_drop_le_gap: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |-> (left_q <= gap_q))
		else $error("dropped count above gap count");

	// Repaired total steps by exactly the repair flag
	a_rep_step: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> (rep_cnt_q == ($past(rep_cnt_q) + 32'($past(hit_q)))))
		else $error("repaired total out of step");

	// No new chunk before the clearing pass is over
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("chunk taken during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_sequence_gap_loss_tracker_top.sv =====
// Self-checking testbench for sequence_gap_loss_tracker_top: directed and random chunk streams,
// checked against an in-bench tracker of the missing-number table.
// Depends on sglt_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_sequence_gap_loss_tracker_top;

	localparam int TABLE_SLOTS    = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 2 * TABLE_SLOTS + 8;
	localparam int RANDOM_CHUNKS  = 985;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic [sglt_pkg::IN_W-1:0]    s_axis_tdata  = '0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [sglt_pkg::OUT_W-1:0]   m_axis_tdata;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;

	always #10 clk = ~clk;

	sequence_gap_loss_tracker_top #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	// Tracker state mirrored in the bench
	bit                           seen_first;
	logic [sglt_pkg::SEQ_W-1:0]   top_seq;
	bit                           miss_valid [TABLE_SLOTS];
	logic [sglt_pkg::SEQ_W-1:0]   miss_seq   [TABLE_SLOTS];
	logic [sglt_pkg::TIME_W-1:0]  miss_time  [TABLE_SLOTS];
	logic [sglt_pkg::CNT_W-1:0]   repaired_tally;
	logic [sglt_pkg::CNT_W-1:0]   loss_tally;

	sglt_pkg::result_t            pending_reports [$];
	sglt_pkg::result_t            got_report;
	sglt_pkg::result_t            want_report;

	int                 mismatches;
	int                 chunks_sent;
	int                 reports_checked;
	int                 repairs_seen;
	int                 drops_seen;
	int                 burst_left;
	int                 stall_cycles;
	logic [15:0]        rx_cycle;
	logic [1:0]         rx_mode;

	// Apply one chunk to the mirrored tracker and return the report it should produce.
	function automatic sglt_pkg::result_t track_chunk(input logic [sglt_pkg::SEQ_W-1:0] seq,
			input logic [sglt_pkg::TIME_W-1:0] stamp);
		sglt_pkg::result_t            r;
		int                           hit;
		int                           i;
		logic [sglt_pkg::SEQ_W-1:0]   next_seq;
		logic [sglt_pkg::CNT_W-1:0]   left;
		r = '0;
		if (!seen_first) begin
			seen_first = 1'b1;
			top_seq = seq;
		end else begin
			hit = -1;
			for (i = 0; i < TABLE_SLOTS; i++) begin
				if (hit < 0 && miss_valid[i] && miss_seq[i] == seq)
					hit = i;
			end
			if (hit >= 0) begin
				r.was_repaired = 1'b1;
				r.repair_detect_time = miss_time[hit];
				miss_valid[hit] = 1'b0;
				repaired_tally = repaired_tally + 1;
			end
			// 33-bit compare: nothing can exceed top_seq + 1 once top_seq is all ones
			if ({1'b0, seq} > {1'b0, top_seq} + 33'd1) begin
				r.gap_count = seq - top_seq - 1;
				left = r.gap_count;
				next_seq = top_seq + 1;
				for (i = 0; i < TABLE_SLOTS && left != 0; i++) begin
					if (!miss_valid[i]) begin
						miss_valid[i] = 1'b1;
						miss_seq[i] = next_seq;
						miss_time[i] = stamp;
						next_seq = next_seq + 1;
						left = left - 1;
					end
				end
				r.gap_dropped = left;
				loss_tally = loss_tally + r.gap_count;
			end
			if (seq > top_seq)
				top_seq = seq;
		end
		r.repaired_total = repaired_tally;
		r.loss_total = loss_tally;
		return r;
	endfunction

	// Pick one number still listed as missing; returns 0 if the table is empty.
	function automatic bit pick_missing(output logic [sglt_pkg::SEQ_W-1:0] seq);
		int idx [$];
		int i;
		seq = '0;
		for (i = 0; i < TABLE_SLOTS; i++) begin
			if (miss_valid[i])
				idx.push_back(i);
		end
		if (idx.size() == 0)
			return 1'b0;
		seq = miss_seq[idx[$urandom_range(0, idx.size() - 1)]];
		return 1'b1;
	endfunction

	function automatic void check_field(input string name,
			input logic [sglt_pkg::TIME_W-1:0] want,
			input logic [sglt_pkg::TIME_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// One chunk transfer. Valid stays high between back-to-back transfers of a burst.
	task automatic send_chunk(input logic [sglt_pkg::SEQ_W-1:0] seq,
			input logic [sglt_pkg::TIME_W-1:0] stamp);
		int idle_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (idle_len != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= {stamp, seq};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_reports.push_back(track_chunk(seq, stamp));
		chunks_sent++;
	endtask

	// Baseline, in-order chunk, small gap, repairs, repeats and stale numbers.
	task automatic test_baseline_and_repair();
		send_chunk(32'd100, 64'hFFFF_FFFF_FFFF_FFFF);
		send_chunk(32'd101, 64'h0);
		send_chunk(32'd105, {$urandom, $urandom});
		send_chunk(32'd103, {$urandom, $urandom});
		send_chunk(32'd103, {$urandom, $urandom});
		send_chunk(32'd50, 64'h0);
		send_chunk(32'd102, {$urandom, $urandom});
		send_chunk(32'd104, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// Fill the table past capacity, then check that freed slots are reused lowest first.
	task automatic test_table_overflow();
		send_chunk(32'd110, {$urandom, $urandom});
		send_chunk(32'd107, {$urandom, $urandom});
		send_chunk(32'd180, {$urandom, $urandom});
		send_chunk(32'd250, {$urandom, $urandom});
		send_chunk(32'd120, {$urandom, $urandom});
		send_chunk(32'd252, {$urandom, $urandom});
		send_chunk(32'd251, {$urandom, $urandom});
		send_chunk(32'd108, {$urandom, $urandom});
		send_chunk(32'd106, {$urandom, $urandom});
		send_chunk(32'd109, {$urandom, $urandom});
		send_chunk(32'd252, {$urandom, $urandom});
	endtask

	// Mostly well-formed streams: in order, small gaps, late arrivals of missing numbers;
	// the repair share shifts every hundred chunks so the table both fills and drains.
	task automatic test_random_traffic(input int count);
		int                           n;
		int                           roll;
		int                           repair_pct;
		bit                           hit;
		logic [sglt_pkg::SEQ_W-1:0]   seq;
		repair_pct = 30;
		for (n = 0; n < count; n++) begin
			if (n % 100 == 0)
				repair_pct = $urandom_range(10, 75);
			hit = 1'b0;
			if ($urandom_range(0, 99) < repair_pct)
				hit = pick_missing(seq);
			if (!hit) begin
				roll = $urandom_range(0, 99);
				if (roll < 55)
					seq = top_seq + 1;
				else if (roll < 80)
					seq = top_seq + 1 + $urandom_range(1, 6);
				else if (roll < 88)
					seq = top_seq + 1 + $urandom_range(20, 90);
				else if (roll < 98)
					seq = top_seq - $urandom_range(0, 40);
				else
					seq = top_seq + $urandom_range(1000, 200000);
			end
			send_chunk(seq, {$urandom, $urandom});
		end
	endtask

	// Jump to the top of the number range; after that no chunk may open a gap.
	task automatic test_top_wrap();
		int                           n;
		bit                           hit;
		logic [sglt_pkg::SEQ_W-1:0]   seq;
		send_chunk(32'hFFFF_FFF0, 64'h0);
		send_chunk(32'hFFFF_FFFF, {$urandom, $urandom});
		send_chunk(32'h0000_0000, {$urandom, $urandom});
		send_chunk(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		for (n = 0; n < 40; n++) begin
			hit = 1'b0;
			if ($urandom_range(0, 1) == 1)
				hit = pick_missing(seq);
			if (!hit)
				seq = $urandom;
			send_chunk(seq, {$urandom, $urandom});
		end
	endtask

	// Result checker and receiver stall pattern
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got_report = m_axis_tdata[sglt_pkg::RES_W-1:0];
			if (pending_reports.size() == 0) begin
				$error("result transfer with no chunk outstanding: %0h", got_report);
				mismatches++;
			end else begin
				want_report = pending_reports.pop_front();
				check_field("was_repaired", want_report.was_repaired, got_report.was_repaired);
				check_field("repair_detect_time", want_report.repair_detect_time,
					got_report.repair_detect_time);
				check_field("gap_count", want_report.gap_count, got_report.gap_count);
				check_field("gap_dropped", want_report.gap_dropped, got_report.gap_dropped);
				check_field("repaired_total", want_report.repaired_total,
					got_report.repaired_total);
				check_field("loss_total", want_report.loss_total, got_report.loss_total);
				reports_checked++;
				repairs_seen += want_report.was_repaired;
				drops_seen += (want_report.gap_dropped != 0);
			end
		end
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle[5:0] == 6'd0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= $urandom_range(0, 1);
			2'd2: m_axis_tready <= (rx_cycle[1:0] == 2'd3);
			default: m_axis_tready <= rx_cycle[4];
		endcase
	end

	// Watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		seen_first = 1'b0;
		top_seq = '0;
		repaired_tally = '0;
		loss_tally = '0;
		mismatches = 0;
		chunks_sent = 0;
		reports_checked = 0;
		repairs_seen = 0;
		drops_seen = 0;
		burst_left = 0;
		stall_cycles = 0;
		rx_cycle = '0;
		rx_mode = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			miss_valid[i] = 1'b0;
			miss_seq[i] = '0;
			miss_time[i] = '0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_baseline_and_repair();
		test_table_overflow();
		test_random_traffic(RANDOM_CHUNKS);
		test_top_wrap();
		s_axis_tvalid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d chunks, checked %0d reports: %0d repairs, %0d with dropped gaps,",
			chunks_sent, reports_checked, repairs_seen, drops_seen);
		$display("table overflow and reuse, and the top-of-range wrap were exercised.");
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
